// ----- rtl/xrg_pkg.sv -----
// ----------------------------------------------------------------------------
// xrg_pkg: shared definitions for the xoshiro random generator
// Constants, action codes and the controller/datapath command and status types.
// ----------------------------------------------------------------------------
`default_nettype none

package xrg_pkg;

  localparam logic [63:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_MUL_A    = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_MUL_B    = 64'h94D049BB133111EB;

  localparam logic [1:0] ACT_RESTART = 2'd0;
  localparam logic [1:0] ACT_RAW     = 2'd1;
  localparam logic [1:0] ACT_BOUNDED = 2'd2;

  localparam logic [1:0] REG_SEED   = 2'd0;
  localparam logic [1:0] REG_STREAM = 2'd1;
  localparam logic [1:0] REG_DERIVE = 2'd2;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD_ZERO,
    DP_LOAD_SEED,
    DP_LOAD_STREAM,
    DP_LOAD_MIXX,
    DP_LOAD_Z,
    DP_ADD,
    DP_MUL0,
    DP_MUL1,
    DP_MUL2,
    DP_XS,
    DP_STORE,
    DP_ZFIX,
    DP_DRAW,
    DP_CAPTURE,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_THR_LATCH,
    DP_OUT_LOAD
  } dp_op_t;

  typedef enum logic [1:0] {
    EMIT_VAL,
    EMIT_REM,
    EMIT_NOV
  } emit_sel_t;

  typedef struct packed {
    dp_op_t    op;
    logic      mul_b;     // second multiply pass of the mix
    logic [1:0] word_idx;
    logic      div_final; // divide the kept draw instead of minus bound
    emit_sel_t emit_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
    logic below_thr;
    logic in_bound_zero;
    logic derive;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/xrg_datapath.sv -----
// ----------------------------------------------------------------------------
// xrg_datapath: generator state, mixer, remainder unit and output register
// Executes one command per cycle from the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module xrg_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire xrg_pkg::dp_cmd_t  cmd,
  output xrg_pkg::dp_status_t    status,
  input  wire logic              cfg_write_enable,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [63:0]       cfg_data,
  input  wire logic [63:0]       in_bound,
  output logic [63:0]            out_value,
  output logic                   out_no_value
);
  import xrg_pkg::*;

  logic [63:0] w_r [4];
  logic [63:0] seed_r, stream_r;
  logic        derive_r;
  logic [63:0] acc_r, z_r, prod_r;
  logic [63:0] bound_r, thr_r, val_r;
  logic [63:0] rem_r, dvd_r;
  logic [5:0]  cnt_r;
  logic [63:0] out_value_r;
  logic        out_no_value_r;

  logic [63:0] mconst, acc_add, draw_mul5, draw_rot, draw_res;
  logic [31:0] m_a, m_b;
  logic [63:0] mprod;
  logic [64:0] trial;
  logic [63:0] rem_step;

  always_comb begin
    mconst = cmd.mul_b ? MIX_MUL_B : MIX_MUL_A;
    m_a = z_r[31:0];
    m_b = mconst[31:0];
    if (cmd.op == DP_MUL1) begin
      m_a = z_r[63:32];
    end else if (cmd.op == DP_MUL2) begin
      m_b = mconst[63:32];
    end
  end

  assign mprod     = 64'(m_a) * 64'(m_b);
  assign acc_add   = acc_r + GOLDEN_GAMMA;
  assign draw_mul5 = w_r[1] + (w_r[1] << 2);
  assign draw_rot  = {draw_mul5[56:0], draw_mul5[63:57]};
  assign draw_res  = draw_rot + (draw_rot << 3);
  assign trial     = {rem_r, dvd_r[63]};
  assign rem_step = (trial >= {1'b0, bound_r}) ? 64'(trial - {1'b0, bound_r}) : trial[63:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r   <= '0;
      stream_r <= '0;
      derive_r <= 1'b0;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        REG_SEED:   seed_r   <= cfg_data;
        REG_STREAM: stream_r <= cfg_data;
        REG_DERIVE: derive_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op) inside
      DP_LOAD_ZERO:   acc_r <= '0;
      DP_LOAD_SEED:   acc_r <= seed_r;
      DP_LOAD_STREAM: acc_r <= stream_r;
      DP_LOAD_MIXX:   acc_r <= seed_r ^ z_r;
      DP_LOAD_Z:      acc_r <= z_r;
      DP_ADD: begin
        acc_r <= acc_add;
        z_r   <= acc_add ^ (acc_add >> 30);
      end
      DP_MUL0: prod_r <= mprod;
      DP_MUL1, DP_MUL2: prod_r[63:32] <= prod_r[63:32] + mprod[31:0];
      DP_XS: z_r <= cmd.mul_b ? (prod_r ^ (prod_r >> 31)) : (prod_r ^ (prod_r >> 27));
      DP_STORE: w_r[cmd.word_idx] <= z_r;
      DP_ZFIX: begin
        if ((w_r[0] | w_r[1] | w_r[2] | w_r[3]) == '0) begin
          w_r[0] <= GOLDEN_GAMMA;
        end
      end
      DP_DRAW: begin
        val_r  <= draw_res;
        w_r[2] <= w_r[2] ^ w_r[0] ^ (w_r[1] << 17);
        w_r[3] <= {(w_r[3][18:0] ^ w_r[1][18:0]), (w_r[3][63:19] ^ w_r[1][63:19])};
        w_r[1] <= w_r[1] ^ w_r[2] ^ w_r[0];
        w_r[0] <= w_r[0] ^ w_r[3] ^ w_r[1];
      end
      DP_CAPTURE: bound_r <= in_bound;
      DP_DIV_INIT: begin
        rem_r <= '0;
        dvd_r <= cmd.div_final ? val_r : (64'd0 - bound_r);
        cnt_r <= '0;
      end
      DP_DIV_STEP: begin
        rem_r <= rem_step;
        dvd_r <= dvd_r << 1;
        cnt_r <= cnt_r + 6'd1;
      end
      DP_THR_LATCH: thr_r <= rem_r;
      DP_OUT_LOAD: begin
        case (cmd.emit_sel)
          EMIT_VAL: begin
            out_value_r    <= val_r;
            out_no_value_r <= 1'b0;
          end
          EMIT_REM: begin
            out_value_r    <= rem_r;
            out_no_value_r <= 1'b0;
          end
          default: begin
            out_value_r    <= '0;
            out_no_value_r <= 1'b1;
          end
        endcase
      end
      default: ;
    endcase
  end

  assign status.div_last      = (cnt_r == 6'd63);
  assign status.below_thr     = (val_r < thr_r);
  assign status.in_bound_zero = (in_bound == '0);
  assign status.derive        = derive_r;

  assign out_value    = out_value_r;
  assign out_no_value = out_no_value_r;

endmodule

`default_nettype wire

// ----- rtl/xrg_ctrl.sv -----
// ----------------------------------------------------------------------------
// xrg_ctrl: sequencer for reseeding, draws, rejection and remainders
// Issues one datapath command per cycle and owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module xrg_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          in_action,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output xrg_pkg::dp_cmd_t         cmd,
  input  wire xrg_pkg::dp_status_t status
);
  import xrg_pkg::*;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_ADD, S_MUL0, S_MUL1, S_MUL2, S_XS, S_POST, S_ZFIX,
    S_DRAW, S_CHECK, S_DIVINIT, S_DIV, S_DIVEND, S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    P_STREAM, P_OUTER, P_W0, P_W1, P_W2, P_W3
  } purpose_t;

  state_t    state_r, state_nxt;
  purpose_t  purpose_r, purpose_nxt;
  logic      pass_b_r, pass_b_nxt;
  logic      bounded_r, bounded_nxt;
  logic      final_r, final_nxt;
  emit_sel_t emit_r, emit_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      can_load;

  assign can_load = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    purpose_nxt   = purpose_r;
    pass_b_nxt    = pass_b_r;
    bounded_nxt   = bounded_r;
    final_nxt     = final_r;
    emit_nxt      = emit_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.op        = DP_NOP;
    cmd.mul_b     = pass_b_r;
    cmd.word_idx  = 2'd0;
    cmd.div_final = final_r;
    cmd.emit_sel  = emit_r;
    unique case (state_r)
      S_INIT: begin
        cmd.op      = DP_LOAD_ZERO;
        purpose_nxt = P_W0;
        state_nxt   = S_ADD;
      end
      S_IDLE: begin
        if (in_valid) begin
          case (in_action)
            ACT_RESTART: begin
              cmd.op      = status.derive ? DP_LOAD_STREAM : DP_LOAD_SEED;
              purpose_nxt = status.derive ? P_STREAM : P_W0;
              state_nxt   = S_ADD;
            end
            ACT_RAW: begin
              bounded_nxt = 1'b0;
              state_nxt   = S_DRAW;
            end
            ACT_BOUNDED: begin
              if (status.in_bound_zero) begin
                emit_nxt  = EMIT_NOV;
                state_nxt = S_EMIT;
              end else begin
                cmd.op      = DP_CAPTURE;
                bounded_nxt = 1'b1;
                final_nxt   = 1'b0;
                state_nxt   = S_DIVINIT;
              end
            end
            default: ;
          endcase
        end
      end
      S_ADD: begin
        cmd.op     = DP_ADD;
        pass_b_nxt = 1'b0;
        state_nxt  = S_MUL0;
      end
      S_MUL0: begin
        cmd.op    = DP_MUL0;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.op    = DP_MUL1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.op    = DP_MUL2;
        state_nxt = S_XS;
      end
      S_XS: begin
        cmd.op = DP_XS;
        if (!pass_b_r) begin
          pass_b_nxt = 1'b1;
          state_nxt  = S_MUL0;
        end else begin
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        state_nxt = S_ADD;
        unique case (purpose_r)
          P_STREAM: begin
            cmd.op      = DP_LOAD_MIXX;
            purpose_nxt = P_OUTER;
          end
          P_OUTER: begin
            cmd.op      = DP_LOAD_Z;
            purpose_nxt = P_W0;
          end
          P_W0: begin
            cmd.op      = DP_STORE;
            cmd.word_idx = 2'd0;
            purpose_nxt = P_W1;
          end
          P_W1: begin
            cmd.op      = DP_STORE;
            cmd.word_idx = 2'd1;
            purpose_nxt = P_W2;
          end
          P_W2: begin
            cmd.op      = DP_STORE;
            cmd.word_idx = 2'd2;
            purpose_nxt = P_W3;
          end
          default: begin
            cmd.op       = DP_STORE;
            cmd.word_idx = 2'd3;
            state_nxt    = S_ZFIX;
          end
        endcase
      end
      S_ZFIX: begin
        cmd.op    = DP_ZFIX;
        state_nxt = S_IDLE;
      end
      S_DRAW: begin
        cmd.op = DP_DRAW;
        if (bounded_r) begin
          state_nxt = S_CHECK;
        end else begin
          emit_nxt  = EMIT_VAL;
          state_nxt = S_EMIT;
        end
      end
      S_CHECK: begin
        if (status.below_thr) begin
          state_nxt = S_DRAW;
        end else begin
          final_nxt = 1'b1;
          state_nxt = S_DIVINIT;
        end
      end
      S_DIVINIT: begin
        cmd.op    = DP_DIV_INIT;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = DP_DIV_STEP;
        if (status.div_last) begin
          state_nxt = S_DIVEND;
        end
      end
      S_DIVEND: begin
        if (!final_r) begin
          cmd.op    = DP_THR_LATCH;
          state_nxt = S_DRAW;
        end else begin
          emit_nxt  = EMIT_REM;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (can_load) begin
          cmd.op        = DP_OUT_LOAD;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      purpose_r   <= P_W0;
      pass_b_r    <= 1'b0;
      bounded_r   <= 1'b0;
      final_r     <= 1'b0;
      emit_r      <= EMIT_VAL;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      purpose_r   <= purpose_nxt;
      pass_b_r    <= pass_b_nxt;
      bounded_r   <= bounded_nxt;
      final_r     <= final_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // A result only appears after the emit step.
  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result valid without emit step");

  // A waiting result is never dropped.
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r)
    else $error("stalled result lost");

  // The remainder unit ends after its last step.
  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && status.div_last) |=> state_r == S_DIVEND)
    else $error("divide did not finish");

  // Seed words are stored only while expanding.
  a_store_purpose: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_STORE) |-> (purpose_r != P_STREAM && purpose_r != P_OUTER))
    else $error("store outside seed expansion");

endmodule

`default_nettype wire

// ----- rtl/xoshiro_random_generator.sv -----
// ----------------------------------------------------------------------------
// xoshiro_random_generator: xoshiro256** generator with bounded draws
// Reseeds from a configured or derived seed; raw and unbiased bounded draws.
// ----------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  in       input      in_valid/in_stall   in_action, in_bound
//  out      output     out_valid/out_stall out_value, out_no_value
//  cfg      input      cfg_write_enable    cfg_index, cfg_data
//
// Raw draw: a draw step, then an emit step into the output register. Restart:
// the mix sequence on one 32x32 multiplier, once per state word and twice
// more with derivation. Bounded draw: the one-bit-per-cycle remainder unit
// run twice, plus a draw and a check per rejected draw.
// After reset the generator expands seed zero with in_stall high.
// A finished result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module xoshiro_random_generator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic [63:0] in_bound,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_value,
  output logic             out_no_value,
  input  wire logic        cfg_write_enable,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  import xrg_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  xrg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_action (in_action),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  xrg_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_bound         (in_bound),
    .out_value        (out_value),
    .out_no_value     (out_no_value)
  );

endmodule

`default_nettype wire
